@@ hdl/morse_keyer_assert.svh @@
// Assertion macros used by the keyer queue.
`ifndef MORSE_KEYER_ASSERT_SVH
`define MORSE_KEYER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define MK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MK_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MK_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/mk_pkg.sv @@
package mk_pkg;

  // Sizes of the fixed fields and the default queue depth.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CODE_W          = 14;
  localparam int UNIT_W          = 16;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  // Register index codes (taken from the word address bit).
  localparam logic REG_UNIT_TICKS = 1'b0;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 16'd1;

  // Gap codes: space is three units off, anything unknown is seven.
  localparam logic [CODE_W-1:0] GAP_SPACE = 14'h0002;
  localparam logic [CODE_W-1:0] GAP_WORD  = 14'h0004;

  // Sender phases.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CODE,
    PH_TRAIL,
    PH_GAP
  } phase_t;

  // Status from the sender to the top level.
  typedef struct packed {
    logic pop;
    logic key;
    logic busy;
  } snd_status_t;

  // Letter codes A to Z, one bit per unit, sent LSB first.
  localparam logic [CODE_W-1:0] LETTER_CODE [26] = '{
    14'd29,   14'd343,  14'd1495, 14'd87,   14'd1,    14'd373,  14'd375,
    14'd85,   14'd5,    14'd7645, 14'd471,  14'd349,  14'd119,  14'd23,
    14'd1911, 14'd1501, 14'd7543, 14'd93,   14'd21,   14'd7,    14'd117,
    14'd469,  14'd477,  14'd1879, 14'd7639, 14'd1399
  };

  // Case-folding lookup of one ASCII byte.
  function automatic logic [CODE_W-1:0] char_to_code(input logic [7:0] c);
    logic [7:0] up_idx;
    logic [7:0] lo_idx;
    up_idx = c - 8'h41;
    lo_idx = c - 8'h61;
    if (c >= 8'h41 && c <= 8'h5A) begin
      char_to_code = LETTER_CODE[up_idx[4:0]];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      char_to_code = LETTER_CODE[lo_idx[4:0]];
    end else if (c == 8'h20 || c == 8'h40) begin
      // The at sign is sent as a space.
      char_to_code = GAP_SPACE;
    end else begin
      char_to_code = GAP_WORD;
    end
  endfunction

endpackage

@@ hdl/mk_queue.sv @@
`include "morse_keyer_assert.svh"

module mk_queue #(
  parameter int DEPTH = mk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_i,
  input  logic                          pop_i,
  input  logic [mk_pkg::CODE_W-1:0]     din_i,
  output logic [mk_pkg::CODE_W-1:0]     front_o,
  output logic [$clog2(DEPTH+1)-1:0]    fill_o,
  output logic [$clog2(DEPTH+1)-1:0]    fill_nxt_o
);
  import mk_pkg::*;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CODE_W-1:0] rd_r;
  logic              byp_r;
  logic [CODE_W-1:0] byp_data_r;

  // Pointer and fill updates; push and pop never come in the same cycle.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push_i) begin
      tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_r + FILL_ONE;
    end else if (pop_i) begin
      head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - FILL_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      byp_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      // A push into an empty queue lands on the entry being read.
      byp_r  <= push_i && (tail_r == head_nxt);
    end
  end

  // Code storage with a registered read of the next head entry.
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[tail_r] <= din_i;
    end
    rd_r       <= mem[head_nxt];
    byp_data_r <= din_i;
  end

  assign front_o    = byp_r ? byp_data_r : rd_r;
  assign fill_o     = fill_r;
  assign fill_nxt_o = fill_nxt;

  `MK_ASSERT_IMP(a_push_not_full, clk, rst_n, push_i, fill_r != FILL_W'(DEPTH))
  `MK_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop_i, fill_r != '0)
  `MK_ASSERT_IMP(a_byp_single, clk, rst_n, byp_r, fill_r == FILL_ONE)

endmodule

@@ hdl/mk_sender.sv @@
module mk_sender (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick_i,
  input  logic [mk_pkg::UNIT_W-1:0]   unit_ticks_i,
  input  logic                        q_nonempty_i,
  input  logic [mk_pkg::CODE_W-1:0]   front_i,
  output mk_pkg::snd_status_t         status_o
);
  import mk_pkg::*;

  localparam logic [2:0] UNITS_SPACE = 3'd3;
  localparam logic [2:0] UNITS_WORD  = 3'd7;

  phase_t            phase_r, phase_nxt, cur_phase;
  logic [CODE_W-1:0] shift_r, shift_nxt, cur_shift, shifted;
  logic [2:0]        units_r, units_nxt, cur_units, units_dec;
  logic [UNIT_W-1:0] tick_r, tick_nxt, cur_tick, eff_unit;
  logic              start;
  logic              unit_end;

  // A tick that finds the sender idle takes the next code right away.
  always_comb begin
    start     = tick_i && (phase_r == PH_IDLE) && q_nonempty_i;
    cur_phase = phase_r;
    cur_shift = shift_r;
    cur_units = units_r;
    cur_tick  = tick_r;
    if (start) begin
      cur_tick = '0;
      if (front_i[0]) begin
        cur_shift = front_i;
        cur_phase = PH_CODE;
      end else if (front_i == GAP_SPACE) begin
        cur_units = UNITS_SPACE;
        cur_phase = PH_GAP;
      end else if (front_i == GAP_WORD) begin
        cur_units = UNITS_WORD;
        cur_phase = PH_GAP;
      end
    end
  end

  // Unit length of zero behaves as one tick.
  assign eff_unit  = (unit_ticks_i == '0) ? UNIT_W'(1) : unit_ticks_i;
  assign unit_end  = ({1'b0, cur_tick} + (UNIT_W+1)'(1)) >= {1'b0, eff_unit};
  assign shifted   = cur_shift >> 1;
  assign units_dec = cur_units - 3'd1;

  // Next state: advance the tick counter and close a unit when it expires.
  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    units_nxt = units_r;
    tick_nxt  = tick_r;
    if (tick_i) begin
      phase_nxt = cur_phase;
      shift_nxt = cur_shift;
      units_nxt = cur_units;
      tick_nxt  = cur_tick;
      if (cur_phase != PH_IDLE) begin
        if (unit_end) begin
          tick_nxt = '0;
          unique case (cur_phase)
            PH_CODE: begin
              shift_nxt = shifted;
              if (shifted == '0) begin
                phase_nxt = PH_TRAIL;
              end
            end
            PH_TRAIL: begin
              phase_nxt = PH_IDLE;
            end
            PH_GAP: begin
              units_nxt = units_dec;
              if (units_dec == '0) begin
                phase_nxt = PH_IDLE;
              end
            end
            PH_IDLE: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end else begin
          tick_nxt = cur_tick + 1'b1;
        end
      end
    end
  end

  // Outputs: the key follows the low shift bit while a letter is sent.
  always_comb begin
    status_o.pop  = start;
    status_o.key  = (cur_phase == PH_CODE) && cur_shift[0];
    status_o.busy = (cur_phase != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= '0;
      units_r <= '0;
      tick_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      units_r <= units_nxt;
      tick_r  <= tick_nxt;
    end
  end

endmodule

@@ hdl/morse_keyer.sv @@
// Channel   Dir  Payload                                       Handshake
// in_*      in   tuser: mode; tdata: char_code                 tvalid/tready
// out_*     out  tdata: key, busy, accepted, dropped, count    tvalid/tready
// cfg_*     in   unit_ticks at byte address 0                  APB, pready high
//
// One item per clock unless the output stalls; its result shows the next cycle.
// The whole item is handled in one pass from the state registers to the
// output register, so the rate is set only by the output handshake.
// A stalled result stays in the output register; a new item is still taken
// in the cycle the held result is taken. Reset is synchronous, active low.
module morse_keyer #(
  parameter int QUEUE_DEPTH = mk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] char_code
  input  logic                           in_tuser,   // [0] mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] key_level, [1] busy_res, [2] accepted, [3] dropped,
  // [8:4] queue_count, [15:9] zero
  output logic [15:0]                    out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [mk_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [mk_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [mk_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                           cfg_pready
);
  import mk_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [UNIT_W-1:0] unit_ticks_r;
  logic              accept;
  logic              tick;
  logic              is_char;
  logic              q_full;
  logic              push;
  logic [CODE_W-1:0] code;
  logic [CODE_W-1:0] front;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_nxt;
  snd_status_t       snd;
  logic              out_tvalid_r;
  logic [15:0]       out_tdata_r;
  logic [15:0]       result;

  // Configuration register; writes complete in the APB access phase.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_TICKS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_UNIT_TICKS) begin
      unit_ticks_r <= cfg_pwdata[UNIT_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_UNIT_TICKS: cfg_prdata = {{(CFG_DATA_W-UNIT_W){1'b0}}, unit_ticks_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Input transaction decode.
  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign tick      = accept && in_tuser;
  assign is_char   = accept && !in_tuser;
  assign q_full    = (fill == FILL_W'(QUEUE_DEPTH));
  assign push      = is_char && !q_full;
  assign code      = char_to_code(in_tdata);

  mk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .pop_i      (snd.pop),
    .din_i      (code),
    .front_o    (front),
    .fill_o     (fill),
    .fill_nxt_o (fill_nxt)
  );

  mk_sender u_sender (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_i       (tick),
    .unit_ticks_i (unit_ticks_r),
    .q_nonempty_i (fill != '0),
    .front_i      (front),
    .status_o     (snd)
  );

  // Result word for this transaction.
  assign result = {7'b0, 5'(fill_nxt), is_char && q_full, push, snd.busy, snd.key};

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
